// ===== rtl/assert_macros.svh =====
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off while reset is high
`define ARPU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arpu assertion failed");

// implication in the next cycle, off while reset is high
`define ARPU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arpu assertion failed");

// implication in the next cycle, checked during reset too
`define ARPU_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("arpu assertion failed");

`endif

// ===== rtl/arpu_pkg.sv =====
// package with types and constants of the relocation patch unit
`timescale 1ns / 1ps
package arpu_pkg;

  localparam int ModeW = 9;
  localparam int AddrW = 64;
  localparam int InsnW = 32;
  localparam int LsbW  = 6;
  localparam int LenW  = 7;

  localparam logic [AddrW-1:0] PageMask = 64'hfff;

  localparam logic [1:0] WW_NONE = 2'd0;
  localparam logic [1:0] WW_16   = 2'd1;
  localparam logic [1:0] WW_32   = 2'd2;
  localparam logic [1:0] WW_64   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;

  localparam logic [ModeW-1:0] R_NONE               = 9'd0;
  localparam logic [ModeW-1:0] R_ABS64              = 9'd257;
  localparam logic [ModeW-1:0] R_ABS32              = 9'd258;
  localparam logic [ModeW-1:0] R_ABS16              = 9'd259;
  localparam logic [ModeW-1:0] R_PREL64             = 9'd260;
  localparam logic [ModeW-1:0] R_PREL32             = 9'd261;
  localparam logic [ModeW-1:0] R_PREL16             = 9'd262;
  localparam logic [ModeW-1:0] R_MOVW_UABS_G0       = 9'd263;
  localparam logic [ModeW-1:0] R_MOVW_UABS_G0_NC    = 9'd264;
  localparam logic [ModeW-1:0] R_MOVW_UABS_G1       = 9'd265;
  localparam logic [ModeW-1:0] R_MOVW_UABS_G1_NC    = 9'd266;
  localparam logic [ModeW-1:0] R_MOVW_UABS_G2       = 9'd267;
  localparam logic [ModeW-1:0] R_MOVW_UABS_G2_NC    = 9'd268;
  localparam logic [ModeW-1:0] R_MOVW_UABS_G3       = 9'd269;
  localparam logic [ModeW-1:0] R_MOVW_SABS_G0       = 9'd270;
  localparam logic [ModeW-1:0] R_MOVW_SABS_G1       = 9'd271;
  localparam logic [ModeW-1:0] R_MOVW_SABS_G2       = 9'd272;
  localparam logic [ModeW-1:0] R_LD_PREL_LO19       = 9'd273;
  localparam logic [ModeW-1:0] R_ADR_PREL_LO21      = 9'd274;
  localparam logic [ModeW-1:0] R_ADR_PREL_PG_HI21   = 9'd275;
  localparam logic [ModeW-1:0] R_ADR_PREL_PG_HI21NC = 9'd276;
  localparam logic [ModeW-1:0] R_ADD_ABS_LO12_NC    = 9'd277;
  localparam logic [ModeW-1:0] R_LDST8_ABS_LO12_NC  = 9'd278;
  localparam logic [ModeW-1:0] R_TSTBR14            = 9'd279;
  localparam logic [ModeW-1:0] R_CONDBR19           = 9'd280;
  localparam logic [ModeW-1:0] R_JUMP26             = 9'd282;
  localparam logic [ModeW-1:0] R_CALL26             = 9'd283;
  localparam logic [ModeW-1:0] R_LDST16_ABS_LO12_NC = 9'd284;
  localparam logic [ModeW-1:0] R_LDST32_ABS_LO12_NC = 9'd285;
  localparam logic [ModeW-1:0] R_LDST64_ABS_LO12_NC = 9'd286;
  localparam logic [ModeW-1:0] R_MOVW_PREL_G0       = 9'd287;
  localparam logic [ModeW-1:0] R_MOVW_PREL_G0_NC    = 9'd288;
  localparam logic [ModeW-1:0] R_MOVW_PREL_G1       = 9'd289;
  localparam logic [ModeW-1:0] R_MOVW_PREL_G1_NC    = 9'd290;
  localparam logic [ModeW-1:0] R_MOVW_PREL_G2       = 9'd291;
  localparam logic [ModeW-1:0] R_MOVW_PREL_G2_NC    = 9'd292;
  localparam logic [ModeW-1:0] R_MOVW_PREL_G3       = 9'd293;
  localparam logic [ModeW-1:0] R_LDST128_ABS_LO12NC = 9'd299;

  typedef enum logic [1:0] {OP_ABS, OP_PREL, OP_PAGE} op_t;

  typedef enum logic [2:0] {ENC_16, ENC_12, ENC_14, ENC_19, ENC_26, ENC_ADR} enc_t;

  typedef enum logic [2:0] {KIND_NONE, KIND_DATA, KIND_MOVW, KIND_IMM, KIND_UNSUP} kind_t;

  typedef struct packed {
    kind_t           kind;
    op_t             op;
    enc_t            enc;
    logic [LsbW-1:0] lsb;
    logic [LenW-1:0] len;
    logic            nz;
    logic            chk;
    logic [1:0]      wwidth;
  } ctrl_t;

endpackage

// ===== rtl/aarch64_rela_patch_unit.sv =====
// a result reaches m_axis through the decode, value, shift and encode registers in that order
// throughput: one relocation per cycle while m_axis_tready is high, four register stages (decode, value, shift, encode)
// each stage holds its item while the next one is full and cannot pass its own item on, bubbles are squeezed out
// reset: synchronous rst clears all stage valid bits, payload registers keep their data
`timescale 1ns / 1ps
module aarch64_rela_patch_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,  // place_address, target_value, original_word
  input  logic [8:0]   s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // patched_word
  output logic [3:0]   m_axis_tuser   // write_width, status
);
  import arpu_pkg::*;

  logic             s1_valid, s1_ready;
  ctrl_t            s1_ctrl;
  logic [AddrW-1:0] s1_place, s1_target;
  logic [InsnW-1:0] s1_insn;

  logic             s2_valid, s2_ready;
  ctrl_t            s2_ctrl;
  logic [AddrW-1:0] s2_value;
  logic [InsnW-1:0] s2_insn;

  logic             s3_valid, s3_ready;
  ctrl_t            s3_ctrl;
  logic [AddrW-1:0] s3_shifted;
  logic [InsnW-1:0] s3_insn;

  logic [1:0]       out_width;
  logic [1:0]       out_status;

  arpu_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .mode          (s_axis_tuser),
    .place_address (s_axis_tdata[63:0]),
    .target_value  (s_axis_tdata[127:64]),
    .original_word (s_axis_tdata[159:128]),
    .out_valid     (s1_valid),
    .out_ready     (s1_ready),
    .ctrl          (s1_ctrl),
    .place         (s1_place),
    .target        (s1_target),
    .insn          (s1_insn)
  );

  arpu_value u_value (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_ctrl   (s1_ctrl),
    .place     (s1_place),
    .target    (s1_target),
    .in_insn   (s1_insn),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .ctrl      (s2_ctrl),
    .value     (s2_value),
    .insn      (s2_insn)
  );

  arpu_shift u_shift (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_ctrl   (s2_ctrl),
    .value     (s2_value),
    .in_insn   (s2_insn),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .ctrl      (s3_ctrl),
    .shifted   (s3_shifted),
    .insn      (s3_insn)
  );

  arpu_encode u_encode (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s3_valid),
    .in_ready     (s3_ready),
    .ctrl         (s3_ctrl),
    .shifted      (s3_shifted),
    .insn         (s3_insn),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .patched_word (m_axis_tdata),
    .write_width  (out_width),
    .status       (out_status)
  );

  assign m_axis_tuser = {out_status, out_width};

endmodule

// ===== rtl/arpu_decode.sv =====
// stage one: relocation type decode and input register
`timescale 1ns / 1ps
module arpu_decode (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [arpu_pkg::ModeW-1:0] mode,
  input  logic [arpu_pkg::AddrW-1:0] place_address,
  input  logic [arpu_pkg::AddrW-1:0] target_value,
  input  logic [arpu_pkg::InsnW-1:0] original_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output arpu_pkg::ctrl_t            ctrl,
  output logic [arpu_pkg::AddrW-1:0] place,
  output logic [arpu_pkg::AddrW-1:0] target,
  output logic [arpu_pkg::InsnW-1:0] insn
);
  import arpu_pkg::*;

  ctrl_t ctrl_next;

  function automatic ctrl_t mk(kind_t k, op_t o, enc_t e, logic [LsbW-1:0] lsb,
                               logic [LenW-1:0] len, logic nz, logic chk,
                               logic [1:0] ww);
    ctrl_t c;
    c.kind   = k;
    c.op     = o;
    c.enc    = e;
    c.lsb    = lsb;
    c.len    = len;
    c.nz     = nz;
    c.chk    = chk;
    c.wwidth = ww;
    return c;
  endfunction

  always_comb begin
    case (mode)
      R_NONE:               ctrl_next = mk(KIND_NONE, OP_ABS, ENC_16, 6'd0, 7'd64, 1'b0, 1'b0,
                                           WW_NONE);
      R_ABS64:              ctrl_next = mk(KIND_DATA, OP_ABS, ENC_16, 6'd0, 7'd64, 1'b0, 1'b0,
                                           WW_64);
      R_ABS32:              ctrl_next = mk(KIND_DATA, OP_ABS, ENC_16, 6'd0, 7'd32, 1'b0, 1'b1,
                                           WW_32);
      R_ABS16:              ctrl_next = mk(KIND_DATA, OP_ABS, ENC_16, 6'd0, 7'd16, 1'b0, 1'b1,
                                           WW_16);
      R_PREL64:             ctrl_next = mk(KIND_DATA, OP_PREL, ENC_16, 6'd0, 7'd64, 1'b0, 1'b0,
                                           WW_64);
      R_PREL32:             ctrl_next = mk(KIND_DATA, OP_PREL, ENC_16, 6'd0, 7'd32, 1'b0, 1'b1,
                                           WW_32);
      R_PREL16:             ctrl_next = mk(KIND_DATA, OP_PREL, ENC_16, 6'd0, 7'd16, 1'b0, 1'b1,
                                           WW_16);
      R_MOVW_UABS_G0:       ctrl_next = mk(KIND_MOVW, OP_ABS, ENC_16, 6'd0, 7'd16, 1'b0, 1'b1,
                                           WW_32);
      R_MOVW_UABS_G0_NC:    ctrl_next = mk(KIND_MOVW, OP_ABS, ENC_16, 6'd0, 7'd16, 1'b0, 1'b0,
                                           WW_32);
      R_MOVW_UABS_G1:       ctrl_next = mk(KIND_MOVW, OP_ABS, ENC_16, 6'd16, 7'd16, 1'b0, 1'b1,
                                           WW_32);
      R_MOVW_UABS_G1_NC:    ctrl_next = mk(KIND_MOVW, OP_ABS, ENC_16, 6'd16, 7'd16, 1'b0, 1'b0,
                                           WW_32);
      R_MOVW_UABS_G2:       ctrl_next = mk(KIND_MOVW, OP_ABS, ENC_16, 6'd32, 7'd16, 1'b0, 1'b1,
                                           WW_32);
      R_MOVW_UABS_G2_NC:    ctrl_next = mk(KIND_MOVW, OP_ABS, ENC_16, 6'd32, 7'd16, 1'b0, 1'b0,
                                           WW_32);
      R_MOVW_UABS_G3:       ctrl_next = mk(KIND_MOVW, OP_ABS, ENC_16, 6'd48, 7'd16, 1'b0, 1'b0,
                                           WW_32);
      R_MOVW_SABS_G0:       ctrl_next = mk(KIND_MOVW, OP_ABS, ENC_16, 6'd0, 7'd16, 1'b1, 1'b1,
                                           WW_32);
      R_MOVW_SABS_G1:       ctrl_next = mk(KIND_MOVW, OP_ABS, ENC_16, 6'd16, 7'd16, 1'b1, 1'b1,
                                           WW_32);
      R_MOVW_SABS_G2:       ctrl_next = mk(KIND_MOVW, OP_ABS, ENC_16, 6'd32, 7'd16, 1'b1, 1'b1,
                                           WW_32);
      R_LD_PREL_LO19:       ctrl_next = mk(KIND_IMM, OP_PREL, ENC_19, 6'd2, 7'd19, 1'b0, 1'b1,
                                           WW_32);
      R_ADR_PREL_LO21:      ctrl_next = mk(KIND_IMM, OP_PREL, ENC_ADR, 6'd0, 7'd21, 1'b0, 1'b1,
                                           WW_32);
      R_ADR_PREL_PG_HI21:   ctrl_next = mk(KIND_IMM, OP_PAGE, ENC_ADR, 6'd12, 7'd21, 1'b0, 1'b1,
                                           WW_32);
      R_ADR_PREL_PG_HI21NC: ctrl_next = mk(KIND_IMM, OP_PAGE, ENC_ADR, 6'd12, 7'd21, 1'b0, 1'b0,
                                           WW_32);
      R_ADD_ABS_LO12_NC,
      R_LDST8_ABS_LO12_NC:  ctrl_next = mk(KIND_IMM, OP_ABS, ENC_12, 6'd0, 7'd12, 1'b0, 1'b0,
                                           WW_32);
      R_TSTBR14:            ctrl_next = mk(KIND_IMM, OP_PREL, ENC_14, 6'd2, 7'd14, 1'b0, 1'b1,
                                           WW_32);
      R_CONDBR19:           ctrl_next = mk(KIND_IMM, OP_PREL, ENC_19, 6'd2, 7'd19, 1'b0, 1'b1,
                                           WW_32);
      R_JUMP26,
      R_CALL26:             ctrl_next = mk(KIND_IMM, OP_PREL, ENC_26, 6'd2, 7'd26, 1'b0, 1'b1,
                                           WW_32);
      R_LDST16_ABS_LO12_NC: ctrl_next = mk(KIND_IMM, OP_ABS, ENC_12, 6'd1, 7'd11, 1'b0, 1'b0,
                                           WW_32);
      R_LDST32_ABS_LO12_NC: ctrl_next = mk(KIND_IMM, OP_ABS, ENC_12, 6'd2, 7'd10, 1'b0, 1'b0,
                                           WW_32);
      R_LDST64_ABS_LO12_NC: ctrl_next = mk(KIND_IMM, OP_ABS, ENC_12, 6'd3, 7'd9, 1'b0, 1'b0,
                                           WW_32);
      R_MOVW_PREL_G0:       ctrl_next = mk(KIND_MOVW, OP_PREL, ENC_16, 6'd0, 7'd16, 1'b1, 1'b1,
                                           WW_32);
      R_MOVW_PREL_G0_NC:    ctrl_next = mk(KIND_MOVW, OP_PREL, ENC_16, 6'd0, 7'd16, 1'b0, 1'b0,
                                           WW_32);
      R_MOVW_PREL_G1:       ctrl_next = mk(KIND_MOVW, OP_PREL, ENC_16, 6'd16, 7'd16, 1'b1, 1'b1,
                                           WW_32);
      R_MOVW_PREL_G1_NC:    ctrl_next = mk(KIND_MOVW, OP_PREL, ENC_16, 6'd16, 7'd16, 1'b0, 1'b0,
                                           WW_32);
      R_MOVW_PREL_G2:       ctrl_next = mk(KIND_MOVW, OP_PREL, ENC_16, 6'd32, 7'd16, 1'b1, 1'b1,
                                           WW_32);
      R_MOVW_PREL_G2_NC:    ctrl_next = mk(KIND_MOVW, OP_PREL, ENC_16, 6'd32, 7'd16, 1'b0, 1'b0,
                                           WW_32);
      R_MOVW_PREL_G3:       ctrl_next = mk(KIND_MOVW, OP_PREL, ENC_16, 6'd48, 7'd16, 1'b1, 1'b0,
                                           WW_32);
      R_LDST128_ABS_LO12NC: ctrl_next = mk(KIND_IMM, OP_ABS, ENC_12, 6'd4, 7'd8, 1'b0, 1'b0,
                                           WW_32);
      default:              ctrl_next = mk(KIND_UNSUP, OP_ABS, ENC_16, 6'd0, 7'd64, 1'b0, 1'b0,
                                           WW_NONE);
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ctrl   <= ctrl_next;
      place  <= place_address;
      target <= target_value;
      insn   <= original_word;
    end
  end

endmodule

// ===== rtl/arpu_value.sv =====
// stage two: absolute, pc-relative or page-relative value
`timescale 1ns / 1ps
module arpu_value (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  arpu_pkg::ctrl_t            in_ctrl,
  input  logic [arpu_pkg::AddrW-1:0] place,
  input  logic [arpu_pkg::AddrW-1:0] target,
  input  logic [arpu_pkg::InsnW-1:0] in_insn,
  output logic                       out_valid,
  input  logic                       out_ready,
  output arpu_pkg::ctrl_t            ctrl,
  output logic [arpu_pkg::AddrW-1:0] value,
  output logic [arpu_pkg::InsnW-1:0] insn
);
  import arpu_pkg::*;

  logic [AddrW-1:0] value_next;

  always_comb begin
    case (in_ctrl.op)
      OP_PREL: value_next = target - place;
      OP_PAGE: value_next = (target & ~PageMask) - (place & ~PageMask);
      default: value_next = target;
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ctrl  <= in_ctrl;
      value <= value_next;
      insn  <= in_insn;
    end
  end

endmodule

// ===== rtl/arpu_shift.sv =====
// stage three: arithmetic right shift of the value to the field position
`timescale 1ns / 1ps
module arpu_shift (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  arpu_pkg::ctrl_t            in_ctrl,
  input  logic [arpu_pkg::AddrW-1:0] value,
  input  logic [arpu_pkg::InsnW-1:0] in_insn,
  output logic                       out_valid,
  input  logic                       out_ready,
  output arpu_pkg::ctrl_t            ctrl,
  output logic [arpu_pkg::AddrW-1:0] shifted,
  output logic [arpu_pkg::InsnW-1:0] insn
);
  import arpu_pkg::*;

  logic [AddrW-1:0] shifted_next;

  assign shifted_next = AddrW'($signed(value) >>> in_ctrl.lsb);
  assign in_ready     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ctrl    <= in_ctrl;
      shifted <= shifted_next;
      insn    <= in_insn;
    end
  end

endmodule

// ===== rtl/arpu_encode.sv =====
// stage four: range check, field insert and output register
`timescale 1ns / 1ps
module arpu_encode (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  arpu_pkg::ctrl_t            ctrl,
  input  logic [arpu_pkg::AddrW-1:0] shifted,
  input  logic [arpu_pkg::InsnW-1:0] insn,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [arpu_pkg::AddrW-1:0] patched_word,
  output logic [1:0]                 write_width,
  output logic [1:0]                 status
);
  import arpu_pkg::*;

  logic [AddrW-1:0] ones;
  logic [AddrW-1:0] sign_mask;
  logic [AddrW-1:0] top_mask;
  logic [AddrW-1:0] hi_sign;
  logic             sign_uniform;
  logic             data_ovf;
  logic             neg;
  logic             inv;
  logic [15:0]      movw_imm;
  logic             movw_ovf;
  logic [InsnW-1:0] field;
  logic [InsnW-1:0] movw_insn;
  logic [InsnW-1:0] imm_insn;
  logic [AddrW-1:0] word_next;
  logic [1:0]       width_next;
  logic [1:0]       status_next;

  assign ones         = '1;
  assign sign_mask    = ones << (ctrl.len - 7'd1);
  assign top_mask     = ones << ctrl.len;
  assign hi_sign      = shifted & sign_mask;
  assign sign_uniform = (hi_sign == '0) || (hi_sign == sign_mask);
  assign data_ovf     = !(((shifted & top_mask) == '0) || sign_uniform);
  assign neg          = shifted[AddrW-1];
  assign inv          = ctrl.nz && neg;
  assign movw_imm     = inv ? ~shifted[15:0] : shifted[15:0];
  assign movw_ovf     = inv ? !(&shifted[AddrW-1:16]) : (|shifted[AddrW-1:16]);
  assign field        = shifted[InsnW-1:0] & ~top_mask[InsnW-1:0];

  always_comb begin
    movw_insn = insn;
    if (ctrl.nz) begin
      movw_insn[30:29] = neg ? 2'b00 : 2'b10;
    end
    movw_insn[20:5] = movw_imm;
  end

  always_comb begin
    imm_insn = insn;
    case (ctrl.enc)
      ENC_12:  imm_insn[21:10] = field[11:0];
      ENC_14:  imm_insn[18:5]  = field[13:0];
      ENC_19:  imm_insn[23:5]  = field[18:0];
      ENC_26:  imm_insn[25:0]  = field[25:0];
      ENC_ADR: begin
        imm_insn[30:29] = field[1:0];
        imm_insn[23:5]  = field[20:2];
      end
      default: imm_insn[20:5]  = field[15:0];
    endcase
  end

  always_comb begin
    case (ctrl.kind)
      KIND_NONE: begin
        word_next   = '0;
        width_next  = WW_NONE;
        status_next = ST_OK;
      end
      KIND_DATA: begin
        word_next   = shifted & ~top_mask;
        width_next  = ctrl.wwidth;
        status_next = (ctrl.chk && data_ovf) ? ST_OVF : ST_OK;
      end
      KIND_MOVW: begin
        word_next   = {{(AddrW-InsnW){1'b0}}, movw_insn};
        width_next  = ctrl.wwidth;
        status_next = (ctrl.chk && movw_ovf) ? ST_OVF : ST_OK;
      end
      KIND_IMM: begin
        word_next   = {{(AddrW-InsnW){1'b0}}, imm_insn};
        width_next  = ctrl.wwidth;
        status_next = (ctrl.chk && !sign_uniform) ? ST_OVF : ST_OK;
      end
      default: begin
        word_next   = '0;
        width_next  = WW_NONE;
        status_next = ST_UNSUP;
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      patched_word <= word_next;
      write_width  <= width_next;
      status       <= status_next;
    end
  end

endmodule

// ===== rtl/arpu_checker.sv =====
// port checker for the relocation patch unit and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module arpu_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata,
  input logic [3:0]   m_axis_tuser
);
  import arpu_pkg::*;

  logic        stalled;
  logic [67:0] out_bus;
  logic [1:0]  out_width;
  logic [1:0]  out_status;
  logic        unsup_out;
  logic        no_write;
  logic        narrow_out;

  assign stalled    = m_axis_tvalid && !m_axis_tready;
  assign out_bus    = {m_axis_tuser, m_axis_tdata};
  assign out_width  = m_axis_tuser[1:0];
  assign out_status = m_axis_tuser[3:2];
  assign unsup_out  = m_axis_tvalid && (out_status == ST_UNSUP);
  assign no_write   = (out_width == WW_NONE) && (m_axis_tdata == '0);
  assign narrow_out = m_axis_tvalid && (out_width == WW_16 || out_width == WW_32);

  `ARPU_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_axis_tvalid)
  `ARPU_ASSERT_NEXT(a_out_hold, clk, rst, stalled, m_axis_tvalid && $stable(out_bus))
  `ARPU_ASSERT_IMP(a_unsup_no_write, clk, rst, unsup_out, no_write)
  `ARPU_ASSERT_IMP(a_narrow_clean, clk, rst, narrow_out, m_axis_tdata[63:32] == '0)
  `ARPU_ASSERT_IMP(a_status_code, clk, rst, m_axis_tvalid, out_status != 2'd3)

endmodule

bind aarch64_rela_patch_unit arpu_checker u_arpu_checker (.*);

// ===== verif/reloc_check_pkg.sv =====
// relocation result predictor and scoreboard for the relocation patch unit testbench
`timescale 1ns / 1ps
package reloc_check_pkg;
  import arpu_pkg::*;

  typedef struct {
    logic [8:0]  mode;
    logic [63:0] word;
    logic [1:0]  width;
    logic [1:0]  status;
  } reloc_result_t;

  function automatic logic [63:0] sar64(logic [63:0] x, int unsigned s);
    sar64 = $signed(x) >>> s;
  endfunction

  function automatic logic [31:0] insert_field(enc_t enc, logic [31:0] w, logic [63:0] imm);
    case (enc)
      ENC_16: w[20:5] = imm[15:0];
      ENC_12: w[21:10] = imm[11:0];
      ENC_14: w[18:5] = imm[13:0];
      ENC_19: w[23:5] = imm[18:0];
      ENC_26: w[25:0] = imm[25:0];
      default: begin
        w[30:29] = imm[1:0];
        w[23:5] = imm[20:2];
      end
    endcase
    return w;
  endfunction

  function automatic reloc_result_t apply_relocation(logic [8:0] mode, logic [63:0] p,
                                                     logic [63:0] v, logic [31:0] w);
    kind_t         kind;
    op_t           op;
    enc_t          enc;
    int unsigned   lsb;
    int unsigned   len;
    bit            nz;
    bit            chk;
    bit            ovf;
    logic [1:0]    width;
    logic [63:0]   x;
    logic [63:0]   imm;
    logic [63:0]   t;
    reloc_result_t r;
    kind = KIND_IMM;
    op = OP_ABS;
    enc = ENC_16;
    lsb = 0;
    len = 0;
    nz = 0;
    chk = 1;
    ovf = 0;
    width = WW_32;
    r.mode = mode;
    r.word = '0;
    case (mode)
      R_NONE: begin kind = KIND_NONE; chk = 0; width = WW_NONE; end
      R_ABS64: begin kind = KIND_DATA; len = 64; chk = 0; width = WW_64; end
      R_ABS32: begin kind = KIND_DATA; len = 32; end
      R_ABS16: begin kind = KIND_DATA; len = 16; width = WW_16; end
      R_PREL64: begin kind = KIND_DATA; op = OP_PREL; len = 64; chk = 0; width = WW_64; end
      R_PREL32: begin kind = KIND_DATA; op = OP_PREL; len = 32; end
      R_PREL16: begin kind = KIND_DATA; op = OP_PREL; len = 16; width = WW_16; end
      R_MOVW_UABS_G0: begin kind = KIND_MOVW; end
      R_MOVW_UABS_G0_NC: begin kind = KIND_MOVW; chk = 0; end
      R_MOVW_UABS_G1: begin kind = KIND_MOVW; lsb = 16; end
      R_MOVW_UABS_G1_NC: begin kind = KIND_MOVW; lsb = 16; chk = 0; end
      R_MOVW_UABS_G2: begin kind = KIND_MOVW; lsb = 32; end
      R_MOVW_UABS_G2_NC: begin kind = KIND_MOVW; lsb = 32; chk = 0; end
      R_MOVW_UABS_G3: begin kind = KIND_MOVW; lsb = 48; chk = 0; end
      R_MOVW_SABS_G0: begin kind = KIND_MOVW; nz = 1; end
      R_MOVW_SABS_G1: begin kind = KIND_MOVW; lsb = 16; nz = 1; end
      R_MOVW_SABS_G2: begin kind = KIND_MOVW; lsb = 32; nz = 1; end
      R_LD_PREL_LO19, R_CONDBR19: begin op = OP_PREL; lsb = 2; len = 19; enc = ENC_19; end
      R_ADR_PREL_LO21: begin op = OP_PREL; len = 21; enc = ENC_ADR; end
      R_ADR_PREL_PG_HI21: begin op = OP_PAGE; lsb = 12; len = 21; enc = ENC_ADR; end
      R_ADR_PREL_PG_HI21NC: begin
        op = OP_PAGE; lsb = 12; len = 21; enc = ENC_ADR; chk = 0;
      end
      R_ADD_ABS_LO12_NC, R_LDST8_ABS_LO12_NC: begin len = 12; enc = ENC_12; chk = 0; end
      R_TSTBR14: begin op = OP_PREL; lsb = 2; len = 14; enc = ENC_14; end
      R_JUMP26, R_CALL26: begin op = OP_PREL; lsb = 2; len = 26; enc = ENC_26; end
      R_LDST16_ABS_LO12_NC: begin lsb = 1; len = 11; enc = ENC_12; chk = 0; end
      R_LDST32_ABS_LO12_NC: begin lsb = 2; len = 10; enc = ENC_12; chk = 0; end
      R_LDST64_ABS_LO12_NC: begin lsb = 3; len = 9; enc = ENC_12; chk = 0; end
      R_LDST128_ABS_LO12NC: begin lsb = 4; len = 8; enc = ENC_12; chk = 0; end
      R_MOVW_PREL_G0: begin kind = KIND_MOVW; op = OP_PREL; nz = 1; end
      R_MOVW_PREL_G0_NC: begin kind = KIND_MOVW; op = OP_PREL; chk = 0; end
      R_MOVW_PREL_G1: begin kind = KIND_MOVW; op = OP_PREL; lsb = 16; nz = 1; end
      R_MOVW_PREL_G1_NC: begin kind = KIND_MOVW; op = OP_PREL; lsb = 16; chk = 0; end
      R_MOVW_PREL_G2: begin kind = KIND_MOVW; op = OP_PREL; lsb = 32; nz = 1; end
      R_MOVW_PREL_G2_NC: begin kind = KIND_MOVW; op = OP_PREL; lsb = 32; chk = 0; end
      R_MOVW_PREL_G3: begin kind = KIND_MOVW; op = OP_PREL; lsb = 48; nz = 1; chk = 0; end
      default: begin kind = KIND_UNSUP; chk = 0; width = WW_NONE; end
    endcase

    case (op)
      OP_PREL: x = v - p;
      OP_PAGE: x = (v & ~PageMask) - (p & ~PageMask);
      default: x = v;
    endcase

    case (kind)
      KIND_DATA: begin
        if (len == 64) begin
          r.word = x;
        end else begin
          r.word = x & ((64'd1 << len) - 64'd1);
          t = sar64(x, len - 1);
          ovf = !(t == 64'd0 || t == 64'd1 || t == '1);
        end
      end
      KIND_MOVW: begin
        imm = sar64(x, lsb);
        if (nz) begin
          w[30:29] = 2'b00;
          if (!x[63]) w[30] = 1'b1;
          else imm = ~imm;
        end
        w = insert_field(ENC_16, w, imm);
        ovf = imm > 64'hffff;
        r.word = {32'd0, w};
      end
      KIND_IMM: begin
        imm = sar64(x, lsb);
        w = insert_field(enc, w, imm & ((64'd1 << len) - 64'd1));
        t = sar64(imm, len - 1);
        ovf = !(t == 64'd0 || t == '1);
        r.word = {32'd0, w};
      end
      default: r.word = '0;
    endcase

    r.width = width;
    if (kind == KIND_UNSUP) r.status = ST_UNSUP;
    else if (chk && ovf) r.status = ST_OVF;
    else r.status = ST_OK;
    return r;
  endfunction

  class reloc_scoreboard;
    reloc_result_t expected_q[$];
    int unsigned   mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_input(logic [8:0] mode, logic [63:0] p, logic [63:0] v,
                             logic [31:0] w);
      expected_q.push_back(apply_relocation(mode, p, v, w));
    endfunction

    function void check_result(logic [63:0] word, logic [3:0] user);
      reloc_result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: word %h width %0d status %0d",
                   word, user[1:0], user[3:2]);
        return;
      end
      exp_r = expected_q.pop_front();
      if (word !== exp_r.word || user[1:0] !== exp_r.width || user[3:2] !== exp_r.status)
      begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch mode %0d: expected word %h width %0d status %0d, got %h %0d %0d",
                   exp_r.mode, exp_r.word, exp_r.width, exp_r.status,
                   word, user[1:0], user[3:2]);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
// top-level testbench of the relocation patch unit with directed and random relocations
`timescale 1ns / 1ps
module tb_top;
  import arpu_pkg::*;
  import reloc_check_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;  // place_address, target_value, original_word
  logic [8:0]   s_axis_tuser = '0;  // mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;       // patched_word
  logic [3:0]   m_axis_tuser;       // write_width, status

  reloc_scoreboard sb = new();
  bit              send_burst = 1'b0;
  bit              recv_burst = 1'b0;

  logic [8:0] known_modes [37] = '{
    R_ABS64, R_ABS32, R_ABS16, R_PREL64, R_PREL32, R_PREL16,
    R_MOVW_UABS_G0, R_MOVW_UABS_G0_NC, R_MOVW_UABS_G1, R_MOVW_UABS_G1_NC,
    R_MOVW_UABS_G2, R_MOVW_UABS_G2_NC, R_MOVW_UABS_G3,
    R_MOVW_SABS_G0, R_MOVW_SABS_G1, R_MOVW_SABS_G2,
    R_LD_PREL_LO19, R_ADR_PREL_LO21, R_ADR_PREL_PG_HI21, R_ADR_PREL_PG_HI21NC,
    R_ADD_ABS_LO12_NC, R_LDST8_ABS_LO12_NC, R_TSTBR14, R_CONDBR19, R_JUMP26, R_CALL26,
    R_LDST16_ABS_LO12_NC, R_LDST32_ABS_LO12_NC, R_LDST64_ABS_LO12_NC,
    R_MOVW_PREL_G0, R_MOVW_PREL_G0_NC, R_MOVW_PREL_G1, R_MOVW_PREL_G1_NC,
    R_MOVW_PREL_G2, R_MOVW_PREL_G2_NC, R_MOVW_PREL_G3, R_LDST128_ABS_LO12NC
  };

  aarch64_rela_patch_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // signed offsets spread over all magnitudes, including values at and next to powers of two
  function automatic logic [63:0] offset_value();
    logic [63:0]  r;
    logic [63:0]  b;
    int unsigned  k;
    r = rnd64();
    b = 64'd1 << $urandom_range(0, 63);
    k = $urandom_range(1, 63);
    case ($urandom_range(0, 3))
      0: return r;
      1: return $signed(r << (64 - k)) >>> (64 - k);
      2: begin
        case ($urandom_range(0, 3))
          0: return b - 64'd1;
          1: return b;
          2: return -b;
          default: return -b - 64'd1;
        endcase
      end
      default: return {{48{r[15]}}, r[15:0]};
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_reloc(input logic [8:0] mode, input logic [63:0] p,
                            input logic [63:0] v, input logic [31:0] w);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {w, v, p};
    s_axis_tuser <= mode;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(mode, p, v, w);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_random();
    logic [8:0]  mode;
    logic [63:0] p;
    logic [63:0] v;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) mode = known_modes[$urandom_range(0, 36)];
    else if (pick < 88) mode = R_NONE;
    else mode = 9'($urandom_range(0, 511));
    case ($urandom_range(0, 9))
      0: p = '0;
      1: p = '1;
      default: p = rnd64();
    endcase
    v = offset_value();
    if ($urandom_range(0, 1) == 1) v = p + v;
    send_reloc(mode, p, v, $urandom);
  endtask

  // result side
  initial begin
    int unsigned stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata, m_axis_tuser);
      @(negedge clk);
    end
  end

  initial begin
    #(5_000_000);
    $display("tb_top failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_reloc(R_NONE, '1, '1, '1);
    send_reloc(9'd281, rnd64(), rnd64(), $urandom);
    send_reloc(9'd511, '1, '1, '1);
    send_reloc(9'd1, rnd64(), rnd64(), $urandom);
    send_reloc(R_ABS64, '0, '1, '0);
    send_reloc(R_ABS32, '0, 64'h0000_0000_ffff_ffff, $urandom);
    send_reloc(R_ABS32, '0, 64'h0000_0001_0000_0000, $urandom);
    send_reloc(R_ABS32, '0, 64'hffff_ffff_8000_0000, $urandom);
    send_reloc(R_ABS32, '0, 64'hffff_ffff_7fff_ffff, $urandom);
    send_reloc(R_ABS16, '0, 64'h0000_0000_0000_ffff, $urandom);
    send_reloc(R_ABS16, '0, 64'hffff_ffff_ffff_7fff, $urandom);
    send_reloc(R_PREL16, 64'h1000, 64'h1000 - 64'h8000, $urandom);
    send_reloc(R_PREL64, 64'd1, '0, $urandom);
    send_reloc(R_MOVW_UABS_G0, '0, 64'h1_0000, '1);
    send_reloc(R_MOVW_UABS_G3, '0, '1, '0);
    send_reloc(R_MOVW_SABS_G0, '0, '1, '1);
    send_reloc(R_MOVW_SABS_G1, '0, 64'h0000_0000_ffff_0000, '0);
    send_reloc(R_MOVW_SABS_G2, '0, 64'hffff_0000_0000_0000, $urandom);
    send_reloc(R_MOVW_SABS_G2, '0, 64'hfffe_ffff_ffff_ffff, $urandom);
    send_reloc(R_MOVW_PREL_G0, 64'h10, 64'h8, $urandom);
    send_reloc(R_ADR_PREL_PG_HI21, '0, 64'h1_0000_0000, '0);
    send_reloc(R_ADR_PREL_PG_HI21, 64'hfff, 64'h1000, '1);
    send_reloc(R_ADR_PREL_LO21, 64'h100, 64'h100 + 64'h f_ffff, $urandom);
    send_reloc(R_ADR_PREL_LO21, 64'h100, 64'h100 + 64'h10_0000, $urandom);
    send_reloc(R_CALL26, 64'h800_0000, '0, '1);
    send_reloc(R_JUMP26, '0, 64'h800_0000, '0);
    send_reloc(R_LDST128_ABS_LO12NC, '0, '1, '0);
    drain_results();

    for (int i = 0; i < 1300; i++) begin
      if (i % 400 == 200) drain_results();
      send_random();
    end
    drain_results();
    repeat (10) @(negedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
